[hw/rtl/msgpack_stream_tokenizer_assert.svh]
// assertion macros used by the tokenizer control module
`ifndef MSGPACK_STREAM_TOKENIZER_ASSERT_SVH
`define MSGPACK_STREAM_TOKENIZER_ASSERT_SVH

// clocked on clk, quiet while rst is high
`define MST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never hold
`define MST_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[hw/rtl/mst_pkg.sv]
package mst_pkg;

  localparam int MAX_DEPTH_DEF = 16;

  localparam logic [2:0] K_NULL   = 3'd0;
  localparam logic [2:0] K_INT    = 3'd1;
  localparam logic [2:0] K_BHDR   = 3'd2;
  localparam logic [2:0] K_BBYTE  = 3'd3;
  localparam logic [2:0] K_FLOAT  = 3'd4;
  localparam logic [2:0] K_ARRAY  = 3'd5;
  localparam logic [2:0] K_MAP    = 3'd6;
  localparam logic [2:0] K_STATUS = 3'd7;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_MALFORMED  = 2'd2;
  localparam logic [1:0] ST_DEEP       = 2'd3;

  localparam logic [7:0] C_FIXINT_MAX = 8'h7f;
  localparam logic [7:0] C_NEGFIX_MIN = 8'he0;
  localparam logic [7:0] C_FIXMAP_MAX = 8'h8f;
  localparam logic [7:0] C_FIXARR_MAX = 8'h9f;
  localparam logic [7:0] C_FIXSTR_MAX = 8'hbf;
  localparam logic [7:0] C_NIL        = 8'hc0;
  localparam logic [7:0] C_FALSE      = 8'hc2;
  localparam logic [7:0] C_TRUE       = 8'hc3;
  localparam logic [7:0] C_BIN8       = 8'hc4;
  localparam logic [7:0] C_BIN16      = 8'hc5;
  localparam logic [7:0] C_BIN32      = 8'hc6;
  localparam logic [7:0] C_FLOAT32    = 8'hca;
  localparam logic [7:0] C_FLOAT64    = 8'hcb;
  localparam logic [7:0] C_UINT8      = 8'hcc;
  localparam logic [7:0] C_UINT64     = 8'hcf;
  localparam logic [7:0] C_INT8       = 8'hd0;
  localparam logic [7:0] C_INT64      = 8'hd3;
  localparam logic [7:0] C_STR8       = 8'hd9;
  localparam logic [7:0] C_STR16      = 8'hda;
  localparam logic [7:0] C_STR32      = 8'hdb;
  localparam logic [7:0] C_ARRAY16    = 8'hdc;
  localparam logic [7:0] C_ARRAY32    = 8'hdd;
  localparam logic [7:0] C_MAP16      = 8'hde;
  localparam logic [7:0] C_MAP32      = 8'hdf;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_FIELD   = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    R_OPEN = 2'd0,
    R_DONE = 2'd1,
    R_DEEP = 2'd2,
    R_MAL  = 2'd3
  } rslt_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [31:0] count;
    logic [4:0]  level;
    logic [1:0]  status;
    logic [31:0] consumed;
  } token_t;

  typedef struct packed {
    logic accept;
    logic pop_rd;
    logic pop_chk;
    logic finish;
    logic emit_adv;
  } ctl_cmd_t;

  typedef struct packed {
    logic  discard;
    rslt_t rslt;
    logic  sp_zero;
    logic  sp_one;
    logic  pop_zero;
    logic  fin_has;
    logic  emit_last;
  } dp_stat_t;

  function automatic logic [63:0] sext_sel(input logic [63:0] v, input logic [1:0] sz);
    logic [63:0] r;
    case (sz)
      2'd0:    r = {{56{v[7]}}, v[7:0]};
      2'd1:    r = {{48{v[15]}}, v[15:0]};
      2'd2:    r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/mst_ram.sv]
module mst_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[hw/rtl/mst_datapath.sv]
module mst_datapath
  import mst_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    st,
  output token_t      tok
);
  localparam int SPW = $clog2(MAX_DEPTH + 1);
  localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  phase_t       phase, phase_next;
  logic [7:0]   pcode, pcode_next;
  logic [3:0]   fl, fl_next;
  logic [63:0]  acc, acc_next;
  logic [31:0]  pl, pl_next;
  logic [SPW-1:0] sp, spm1;
  logic [31:0]  pos;
  logic         disc;

  token_t       tk0, tk1, item;
  logic         has_item, item_v;
  rslt_t        rslt_q, r;
  logic         end_q;
  logic [31:0]  consumed_q;
  logic [1:0]   n_q;
  logic         idx;

  logic         push;
  logic [32:0]  push_val;
  logic         open_req;
  logic [2:0]   open_kind;
  logic [31:0]  open_cnt;
  logic [7:0]   fcode;
  logic [63:0]  fval;
  logic         fdone;

  logic [32:0]  rdata, dec;
  logic         ram_we;
  logic [AW-1:0] ram_waddr;
  logic [32:0]  ram_wdata;

  logic         stat_has;
  logic [1:0]   stat_code;
  token_t       stat_tok;

  assign spm1 = sp - 1'b1;

  always_comb begin
    item        = '0;
    item.level  = 5'(sp);
    item_v      = 1'b0;
    r           = R_OPEN;
    phase_next  = phase;
    pcode_next  = pcode;
    fl_next     = fl;
    acc_next    = acc;
    pl_next     = pl;
    push        = 1'b0;
    push_val    = '0;
    open_req    = 1'b0;
    open_kind   = K_ARRAY;
    open_cnt    = '0;
    fdone       = 1'b0;
    fcode       = pcode;
    fval        = acc;

    case (phase)
      PH_FIELD: begin
        acc_next = {acc[55:0], data_byte};
        fl_next  = (fl != 4'd0) ? fl - 4'd1 : fl;
        if (fl_next == 4'd0) begin
          fdone = 1'b1;
          fval  = acc_next;
        end
      end
      PH_PAYLOAD: begin
        item.kind  = K_BBYTE;
        item.value = {56'd0, data_byte};
        item_v     = 1'b1;
        pl_next    = (pl != 32'd0) ? pl - 32'd1 : pl;
        if (pl_next == 32'd0) begin
          phase_next = PH_HEADER;
          r          = R_DONE;
        end
      end
      default: begin
        if (data_byte <= C_FIXINT_MAX) begin
          item.kind  = K_INT;
          item.value = {56'd0, data_byte};
          item_v     = 1'b1;
          r          = R_DONE;
        end else if (data_byte >= C_NEGFIX_MIN) begin
          item.kind  = K_INT;
          item.value = {{56{data_byte[7]}}, data_byte};
          item_v     = 1'b1;
          r          = R_DONE;
        end else if (data_byte <= C_FIXMAP_MAX) begin
          open_req  = 1'b1;
          open_kind = K_MAP;
          open_cnt  = {28'd0, data_byte[3:0]};
        end else if (data_byte <= C_FIXARR_MAX) begin
          open_req  = 1'b1;
          open_kind = K_ARRAY;
          open_cnt  = {28'd0, data_byte[3:0]};
        end else if (data_byte <= C_FIXSTR_MAX) begin
          pl_next    = {27'd0, data_byte[4:0]};
          item.kind  = K_BHDR;
          item.count = {27'd0, data_byte[4:0]};
          item_v     = 1'b1;
          if (data_byte[4:0] == 5'd0) begin
            r = R_DONE;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          r = R_MAL;
          case (data_byte) inside
            C_NIL: begin
              item.kind = K_NULL;
              item_v    = 1'b1;
              r         = R_DONE;
            end
            C_FALSE, C_TRUE: begin
              item.kind  = K_INT;
              item.value = {63'd0, data_byte == C_TRUE};
              item_v     = 1'b1;
              r          = R_DONE;
            end
            [C_UINT8:C_UINT64], [C_INT8:C_INT64]: begin
              r       = R_OPEN;
              fl_next = 4'(4'd1 << data_byte[1:0]);
            end
            C_FLOAT32, C_ARRAY32, C_MAP32, C_BIN32, C_STR32: begin
              r       = R_OPEN;
              fl_next = 4'd4;
            end
            C_FLOAT64: begin
              r       = R_OPEN;
              fl_next = 4'd8;
            end
            C_BIN16, C_STR16, C_ARRAY16, C_MAP16: begin
              r       = R_OPEN;
              fl_next = 4'd2;
            end
            C_BIN8, C_STR8: begin
              r       = R_OPEN;
              fl_next = 4'd1;
            end
            default: r = R_MAL;
          endcase
          if (r == R_OPEN) begin
            pcode_next = data_byte;
            acc_next   = '0;
            phase_next = PH_FIELD;
          end
        end
      end
    endcase

    if (fdone) begin
      phase_next = PH_HEADER;
      case (fcode) inside
        [C_UINT8:C_UINT64]: begin
          item.kind  = K_INT;
          item.value = fval;
          item_v     = 1'b1;
          r          = R_DONE;
        end
        [C_INT8:C_INT64]: begin
          item.kind  = K_INT;
          item.value = sext_sel(fval, fcode[1:0]);
          item_v     = 1'b1;
          r          = R_DONE;
        end
        C_FLOAT32, C_FLOAT64: begin
          item.kind  = K_FLOAT;
          item.value = fval;
          item.count = (fcode == C_FLOAT32) ? 32'd4 : 32'd8;
          item_v     = 1'b1;
          r          = R_DONE;
        end
        C_ARRAY16, C_ARRAY32: begin
          open_req  = 1'b1;
          open_kind = K_ARRAY;
          open_cnt  = fval[31:0];
        end
        C_MAP16, C_MAP32: begin
          open_req  = 1'b1;
          open_kind = K_MAP;
          open_cnt  = fval[31:0];
        end
        default: begin
          pl_next    = fval[31:0];
          item.kind  = K_BHDR;
          item.count = fval[31:0];
          item_v     = 1'b1;
          if (fval[31:0] == 32'd0) begin
            r = R_DONE;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      endcase
    end

    if (open_req) begin
      if (open_cnt == 32'd0) begin
        item.kind = open_kind;
        item_v    = 1'b1;
        r         = R_DONE;
      end else if (sp >= SPW'(MAX_DEPTH)) begin
        r = R_DEEP;
      end else begin
        item.kind  = open_kind;
        item.count = open_cnt;
        item_v     = 1'b1;
        push       = 1'b1;
        push_val   = (open_kind == K_MAP) ? {open_cnt, 1'b0} : {1'b0, open_cnt};
        r          = R_OPEN;
      end
    end
  end

  // stack of items still owed per open container
  assign dec       = rdata - 33'd1;
  assign ram_we    = (cmd.accept && !disc && push) || (cmd.pop_chk && dec != 33'd0);
  assign ram_waddr = cmd.accept ? AW'(sp) : AW'(spm1);
  assign ram_wdata = cmd.accept ? push_val : dec;

  mst_ram #(
    .WIDTH(33),
    .DEPTH(MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.pop_rd),
    .raddr (AW'(spm1)),
    .rdata (rdata)
  );

  always_comb begin
    stat_has  = 1'b1;
    stat_code = ST_OK;
    if (rslt_q == R_DEEP) begin
      stat_code = ST_DEEP;
    end else if (rslt_q == R_MAL) begin
      stat_code = ST_MALFORMED;
    end else if (rslt_q == R_DONE && sp == '0) begin
      stat_code = ST_OK;
    end else if (end_q) begin
      stat_code = ST_INCOMPLETE;
    end else begin
      stat_has = 1'b0;
    end
    stat_tok          = '0;
    stat_tok.kind     = K_STATUS;
    stat_tok.status   = stat_code;
    stat_tok.consumed = (stat_code == ST_OK) ? consumed_q : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      pcode <= '0;
      fl    <= '0;
      acc   <= '0;
      pl    <= '0;
      sp    <= '0;
      pos   <= '0;
      disc  <= 1'b0;
      n_q   <= '0;
      idx   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (disc) begin
          if (buffer_end) begin
            phase <= PH_HEADER;
            pcode <= '0;
            fl    <= '0;
            acc   <= '0;
            pl    <= '0;
            sp    <= '0;
            pos   <= '0;
            disc  <= 1'b0;
          end
        end else begin
          phase <= phase_next;
          pcode <= pcode_next;
          fl    <= fl_next;
          acc   <= acc_next;
          pl    <= pl_next;
          pos   <= pos + 32'd1;
          if (push) begin
            sp <= sp + 1'b1;
          end
        end
      end
      if (cmd.pop_chk && dec == 33'd0) begin
        sp <= spm1;
      end
      if (cmd.finish) begin
        idx <= 1'b0;
        if (rslt_q == R_DEEP || rslt_q == R_MAL) begin
          n_q <= 2'd1;
        end else begin
          n_q <= 2'(has_item) + 2'(stat_has);
        end
        if (stat_has) begin
          if (end_q) begin
            phase <= PH_HEADER;
            pcode <= '0;
            fl    <= '0;
            acc   <= '0;
            pl    <= '0;
            sp    <= '0;
            pos   <= '0;
          end else begin
            disc <= 1'b1;
          end
        end
      end
      if (cmd.emit_adv) begin
        idx <= 1'b1;
      end
    end
  end

  // token payload holding registers
  always_ff @(posedge clk) begin
    if (cmd.accept && !disc) begin
      tk0        <= item;
      has_item   <= item_v;
      rslt_q     <= r;
      end_q      <= buffer_end;
      consumed_q <= pos + 32'd1;
    end
    if (cmd.finish) begin
      if (rslt_q == R_DEEP || rslt_q == R_MAL || !has_item) begin
        tk0 <= stat_tok;
      end else begin
        tk1 <= stat_tok;
      end
    end
  end

  assign tok          = idx ? tk1 : tk0;
  assign st.discard   = disc;
  assign st.rslt      = rslt_q;
  assign st.sp_zero   = (sp == '0);
  assign st.sp_one    = (sp == SPW'(1));
  assign st.pop_zero  = (dec == 33'd0);
  assign st.fin_has   = stat_has || has_item;
  assign st.emit_last = (n_q == 2'd1) || idx;
endmodule

[hw/rtl/mst_ctrl.sv]
`include "msgpack_stream_tokenizer_assert.svh"

module mst_ctrl
  import mst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t st,
  output ctl_cmd_t cmd
);
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EVAL    = 6'b000010,
    S_POP_RD  = 6'b000100,
    S_POP_CHK = 6'b001000,
    S_FIN     = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && !st.discard) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.rslt == R_DONE && !st.sp_zero) begin
          state_next = S_POP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_next = S_POP_CHK;
      end
      S_POP_CHK: begin
        cmd.pop_chk = 1'b1;
        if (!st.pop_zero || st.sp_one) begin
          state_next = S_FIN;
        end else begin
          state_next = S_POP_RD;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = st.fin_has ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = !st.emit_last;
          if (st.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `MST_ASSERT(a_chk_after_rd, state == S_POP_CHK |-> $past(state) == S_POP_RD, "pop check without read")
  `MST_ASSERT(a_pop_nonempty, state == S_POP_RD |-> !st.sp_zero, "pop on empty stack")
  `MST_ASSERT(a_accept_busy, cmd.accept && !st.discard |=> !in_ready, "no eval after byte")
  `MST_ASSERT_NEVER(a_emit_twice, cmd.emit_adv && st.emit_last, "advance past last token")
endmodule

[hw/rtl/msgpack_stream_tokenizer.sv]
// flow: a byte is taken and evaluated, then each stack level it updates is read and
// decremented (each level the byte closes and the enclosing one left open), then the
// byte is finished and its results (0 to 2) emitted; no new byte is taken until they
// are all out, so an output stall holds the input; a byte dropped after a status is not evaluated
// reset: synchronous rst returns to header parsing with an empty stack, no clearing pass
module msgpack_stream_tokenizer
  import mst_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               buffer_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         token_kind,
  output logic signed [63:0] token_value,
  output logic [31:0]        token_count,
  output logic [4:0]         nest_level,
  output logic [1:0]         decode_status,
  output logic [31:0]        bytes_consumed,
  output logic               run_last
);
  ctl_cmd_t cmd;
  dp_stat_t st;
  token_t   tok;

  mst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mst_datapath #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .cmd        (cmd),
    .st         (st),
    .tok        (tok)
  );

  assign token_kind     = tok.kind;
  assign token_value    = tok.value;
  assign token_count    = tok.count;
  assign nest_level     = tok.level;
  assign decode_status  = tok.status;
  assign bytes_consumed = tok.consumed;
  assign run_last       = st.emit_last;
endmodule

[bench/tb_msgpack_stream_tokenizer.sv]
`timescale 1ns / 1ps

module tb_msgpack_stream_tokenizer;
  import mst_pkg::*;

  localparam int DEPTH = MAX_DEPTH_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [31:0] count;
    logic [4:0]  level;
    logic [1:0]  status;
    logic [31:0] consumed;
    logic        last;
  } token_rec_t;

  class token_book;
    phase_t      phase;
    logic [7:0]  pend;
    int          fleft;
    logic [63:0] acc;
    logic [31:0] pay_left;
    logic [32:0] owed[DEPTH];
    int          sp;
    logic [31:0] pos;
    bit          disc;
    token_rec_t  pending_tokens[$];
    token_rec_t  cur[$];
    int          errors;

    function void clear();
      phase = PH_HEADER;
      pend = 0;
      fleft = 0;
      acc = 0;
      pay_left = 0;
      sp = 0;
      pos = 0;
      disc = 0;
    endfunction

    function void emit(logic [2:0] k, logic [63:0] v, logic [31:0] c, logic [1:0] s,
                       logic [31:0] cons);
      token_rec_t t;
      t.kind = k;
      t.value = v;
      t.count = c;
      t.level = (k == K_STATUS) ? 5'd0 : sp[4:0];
      t.status = s;
      t.consumed = cons;
      t.last = 0;
      cur.insert(cur.size(), t);
    endfunction

    function logic [63:0] sx(logic [63:0] v, int bits);
      logic [63:0] r;
      r = v;
      for (int i = bits; i < 64; i++) r[i] = v[bits-1];
      return r;
    endfunction

    function rslt_t open_cont(logic [2:0] k, logic [31:0] c);
      if (c == 0) begin
        emit(k, 0, 0, ST_OK, 0);
        return R_DONE;
      end
      if (sp >= DEPTH) return R_DEEP;
      emit(k, 0, c, ST_OK, 0);
      owed[sp] = (k == K_MAP) ? {c, 1'b0} : {1'b0, c};
      sp++;
      return R_OPEN;
    endfunction

    function rslt_t start_field(logic [7:0] c, int len);
      pend = c;
      fleft = len;
      acc = 0;
      phase = PH_FIELD;
      return R_OPEN;
    endfunction

    function rslt_t bulk_hdr(logic [31:0] len);
      pay_left = len;
      emit(K_BHDR, 0, len, ST_OK, 0);
      if (len == 0) return R_DONE;
      phase = PH_PAYLOAD;
      return R_OPEN;
    endfunction

    function rslt_t header(logic [7:0] c);
      if (c <= C_FIXINT_MAX) begin
        emit(K_INT, {56'd0, c}, 0, ST_OK, 0);
        return R_DONE;
      end
      if (c >= C_NEGFIX_MIN) begin
        emit(K_INT, sx({56'd0, c}, 8), 0, ST_OK, 0);
        return R_DONE;
      end
      if (c <= C_FIXMAP_MAX) return open_cont(K_MAP, {28'd0, c[3:0]});
      if (c <= C_FIXARR_MAX) return open_cont(K_ARRAY, {28'd0, c[3:0]});
      if (c <= C_FIXSTR_MAX) return bulk_hdr({27'd0, c[4:0]});
      if (c == C_NIL) begin
        emit(K_NULL, 0, 0, ST_OK, 0);
        return R_DONE;
      end
      if (c == C_FALSE || c == C_TRUE) begin
        emit(K_INT, (c == C_TRUE) ? 64'd1 : 64'd0, 0, ST_OK, 0);
        return R_DONE;
      end
      if (c >= C_UINT8 && c <= C_UINT64) return start_field(c, 1 << (c - C_UINT8));
      if (c >= C_INT8 && c <= C_INT64) return start_field(c, 1 << (c - C_INT8));
      if (c == C_FLOAT32) return start_field(c, 4);
      if (c == C_FLOAT64) return start_field(c, 8);
      if (c >= C_BIN8 && c <= C_BIN32) return start_field(c, 1 << (c - C_BIN8));
      if (c >= C_STR8 && c <= C_STR32) return start_field(c, 1 << (c - C_STR8));
      if (c == C_ARRAY16 || c == C_MAP16) return start_field(c, 2);
      if (c == C_ARRAY32 || c == C_MAP32) return start_field(c, 4);
      return R_MAL;
    endfunction

    function rslt_t field_done();
      phase = PH_HEADER;
      if (pend >= C_UINT8 && pend <= C_UINT64) begin
        emit(K_INT, acc, 0, ST_OK, 0);
        return R_DONE;
      end
      if (pend >= C_INT8 && pend <= C_INT64) begin
        emit(K_INT, sx(acc, 8 << (pend - C_INT8)), 0, ST_OK, 0);
        return R_DONE;
      end
      if (pend == C_FLOAT32 || pend == C_FLOAT64) begin
        emit(K_FLOAT, acc, (pend == C_FLOAT32) ? 32'd4 : 32'd8, ST_OK, 0);
        return R_DONE;
      end
      if (pend == C_ARRAY16 || pend == C_ARRAY32) return open_cont(K_ARRAY, acc[31:0]);
      if (pend == C_MAP16 || pend == C_MAP32) return open_cont(K_MAP, acc[31:0]);
      return bulk_hdr(acc[31:0]);
    endfunction

    // one accepted byte: work out every token it causes
    function void note_byte(logic [7:0] b, logic e);
      rslt_t r;
      int st;
      logic [31:0] cons;
      cur.delete();
      r = R_OPEN;
      st = -1;
      cons = 0;
      if (disc) begin
        if (e) clear();
        return;
      end
      if (phase == PH_FIELD) begin
        acc = {acc[55:0], b};
        if (fleft > 0) fleft--;
        if (fleft == 0) r = field_done();
      end else if (phase == PH_PAYLOAD) begin
        emit(K_BBYTE, {56'd0, b}, 0, ST_OK, 0);
        if (pay_left > 0) pay_left--;
        if (pay_left == 0) begin
          phase = PH_HEADER;
          r = R_DONE;
        end
      end else begin
        r = header(b);
      end
      if (r == R_DONE) begin
        // close every container that this item completes
        while (sp > 0) begin
          owed[sp-1] = owed[sp-1] - 1;
          if (owed[sp-1] != 0) break;
          sp--;
        end
        if (sp == 0) begin
          st = ST_OK;
          cons = pos + 1;
        end
      end else if (r == R_DEEP) begin
        cur.delete();
        st = ST_DEEP;
      end else if (r == R_MAL) begin
        cur.delete();
        st = ST_MALFORMED;
      end
      pos++;
      if (st < 0 && e) st = ST_INCOMPLETE;
      if (st >= 0) begin
        emit(K_STATUS, 0, 0, st[1:0], cons);
        if (e) clear();
        else disc = 1;
      end
      if (cur.size() > 0) cur[cur.size()-1].last = 1;
      foreach (cur[i]) pending_tokens.insert(pending_tokens.size(), cur[i]);
    endfunction

    function void check(token_rec_t got);
      token_rec_t x;
      if (pending_tokens.size() == 0) begin
        $display("%0t: token with none expected: kind %0d value %h", $time, got.kind,
                 got.value);
        errors++;
        return;
      end
      x = pending_tokens.pop_front();
      if (got.kind !== x.kind) begin
        $display("%0t: token_kind exp %0d got %0d", $time, x.kind, got.kind);
        errors++;
      end
      if (got.value !== x.value) begin
        $display("%0t: token_value exp %h got %h", $time, x.value, got.value);
        errors++;
      end
      if (got.count !== x.count) begin
        $display("%0t: token_count exp %0d got %0d", $time, x.count, got.count);
        errors++;
      end
      if (got.level !== x.level) begin
        $display("%0t: nest_level exp %0d got %0d", $time, x.level, got.level);
        errors++;
      end
      if (got.status !== x.status) begin
        $display("%0t: decode_status exp %0d got %0d", $time, x.status, got.status);
        errors++;
      end
      if (got.consumed !== x.consumed) begin
        $display("%0t: bytes_consumed exp %0d got %0d", $time, x.consumed, got.consumed);
        errors++;
      end
      if (got.last !== x.last) begin
        $display("%0t: run_last exp %0d got %0d", $time, x.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] data_byte;
  logic buffer_end;
  logic out_valid;
  logic out_ready;
  logic [2:0] token_kind;
  logic signed [63:0] token_value;
  logic [31:0] token_count;
  logic [4:0] nest_level;
  logic [1:0] decode_status;
  logic [31:0] bytes_consumed;
  logic run_last;

  token_book book;
  logic [7:0] msg[$];
  int sent_bytes;
  int burst_left;
  bit no_gaps;
  bit long_hold_done;
  bit drained_once;
  int hold_cnt;
  int rx_mode;
  int idle_cycles;

  msgpack_stream_tokenizer i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .buffer_end(buffer_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .token_kind(token_kind),
    .token_value(token_value),
    .token_count(token_count),
    .nest_level(nest_level),
    .decode_status(decode_status),
    .bytes_consumed(bytes_consumed),
    .run_last(run_last)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // receiver: own stall pattern, plus one long hold once traffic is going
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && sent_bytes >= 600) begin
      long_hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    token_rec_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = token_kind;
      got.value = token_value;
      got.count = token_count;
      got.level = nest_level;
      got.status = decode_status;
      got.consumed = bytes_consumed;
      got.last = run_last;
      book.check(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("msgpack_stream_tokenizer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic e);
    if (burst_left == 0 && !no_gaps) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    data_byte <= b;
    buffer_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_byte(b, e);
    sent_bytes++;
  endtask

  task automatic send_msg();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    msg.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending_tokens.size() != 0) @(posedge clk);
  endtask

  function automatic void add_byte(logic [7:0] b);
    msg.insert(msg.size(), b);
  endfunction

  function automatic void put_rand(int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_be(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void gen_value(int d);
    int sel;
    int n;
    int base;
    logic [7:0] c;
    sel = (d > 3) ? $urandom_range(0, 8) : $urandom_range(0, 14);
    case (sel)
      0: add_byte(8'($urandom_range(0, 127)));
      1: add_byte(8'($urandom_range(224, 255)));
      2: begin
        c = 8'($urandom_range(0, 2));
        add_byte(c == 0 ? C_NIL : (c == 1 ? C_FALSE : C_TRUE));
      end
      3: begin
        n = $urandom_range(0, 3);
        add_byte(8'(C_UINT8 + n));
        put_rand(1 << n);
      end
      4: begin
        n = $urandom_range(0, 3);
        add_byte(8'(C_INT8 + n));
        put_rand(1 << n);
      end
      5: begin
        c = $urandom_range(0, 1) ? C_FLOAT32 : C_FLOAT64;
        add_byte(c);
        put_rand(c == C_FLOAT32 ? 4 : 8);
      end
      6: begin
        n = $urandom_range(0, 5);
        add_byte(8'(8'ha0 | n));
        put_rand(n);
      end
      7: begin
        n = $urandom_range(0, 2);
        add_byte(8'(($urandom_range(0, 1) ? C_STR8 : C_BIN8) + n));
        c = 8'($urandom_range(0, 4));
        put_be(32'(c), 1 << n);
        put_rand(int'(c));
      end
      8: begin
        if ($urandom_range(0, 3) == 0) begin
          // reserved or extension code
          c = 8'($urandom_range(0, 2));
          add_byte(c == 0 ? 8'hc1 : (c == 1 ? 8'($urandom_range(8'hc7, 8'hc9))
                                            : 8'($urandom_range(8'hd4, 8'hd8))));
        end else begin
          add_byte(8'($urandom_range(0, 255)));
        end
      end
      9: begin
        n = $urandom_range(0, 3);
        add_byte(8'(8'h90 | n));
        repeat (n) gen_value(d + 1);
      end
      10: begin
        n = $urandom_range(0, 2);
        add_byte(8'(8'h80 | n));
        repeat (2 * n) gen_value(d + 1);
      end
      11, 12: begin
        n = $urandom_range(0, 2);
        c = (sel == 11) ? ($urandom_range(0, 1) ? C_ARRAY16 : C_ARRAY32)
                        : ($urandom_range(0, 1) ? C_MAP16 : C_MAP32);
        add_byte(c);
        put_be(32'(n), (c == C_ARRAY16 || c == C_MAP16) ? 2 : 4);
        repeat ((sel == 12) ? 2 * n : n) gen_value(d + 1);
      end
      default: begin
        // chain of one-element containers around the stack limit
        n = $urandom_range(DEPTH - 2, DEPTH + 1);
        base = msg.size();
        repeat (n) add_byte($urandom_range(0, 1) ? 8'h91 : 8'h81);
        gen_value(d + 4);
        // a map in the chain still owes its value once the inner item closes
        for (int i = base + n - 1; i >= base; i--) begin
          if (msg[i] == 8'h81) add_byte(8'($urandom_range(0, 127)));
        end
      end
    endcase
  endfunction

  task automatic directed();
    logic [7:0] flat[$];
    int lens[$];
    int k;
    flat = '{8'h00, 8'h7f, 8'he0, 8'hff, 8'hc0, 8'hc2, 8'hc3,
             8'hcf, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
             8'hd3, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
             8'hca, 8'h3f, 8'h80, 8'h00, 8'h00,
             8'hcb, 8'h40, 8'h09, 8'h21, 8'hfb, 8'h54, 8'h44, 8'h2d, 8'h18,
             8'h90, 8'h80, 8'ha0, 8'hc1, 8'hc7, 8'h01,
             8'h92, 8'h01, 8'ha2, 8'h61, 8'h62, 8'h55, 8'h66,
             8'h81, 8'h01, 8'hc4, 8'h00, 8'h77, 8'hdc, 8'h00};
    lens = '{1, 1, 1, 1, 1, 1, 1, 9, 9, 5, 9, 1, 1, 1, 1, 2, 2, 5, 5, 2};
    k = 0;
    foreach (lens[i]) begin
      repeat (lens[i]) begin
        add_byte(flat[k]);
        k++;
      end
      send_msg();
    end
    repeat (DEPTH + 1) add_byte(8'h91);
    add_byte(8'h05);
    send_msg();
  endtask

  initial begin
    int cut;
    book = new();
    book.clear();
    book.errors = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    buffer_end = 1'b0;
    out_ready = 1'b0;
    long_hold_done = 1'b0;
    drained_once = 1'b0;
    hold_cnt = 0;
    rx_mode = 0;
    idle_cycles = 0;
    sent_bytes = 0;
    burst_left = 0;
    no_gaps = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed();
    while (sent_bytes < 2000) begin
      if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
      if ($urandom_range(0, 7) == 0) begin
        put_rand($urandom_range(1, 6));
      end else begin
        gen_value(0);
        if ($urandom_range(0, 1)) put_rand($urandom_range(1, 3));
        if ($urandom_range(0, 6) == 0) begin
          cut = $urandom_range(1, msg.size());
          while (msg.size() > cut) void'(msg.pop_back());
        end
      end
      send_msg();
      if (sent_bytes > 1200 && !drained_once) begin
        wait_drained();
        drained_once = 1'b1;
      end
    end
    wait_drained();
    repeat (60) @(posedge clk);
    if (book.errors == 0 && book.pending_tokens.size() == 0) begin
      $display("msgpack_stream_tokenizer regression: pass");
    end else begin
      $display("msgpack_stream_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
